FILE: design/paa_pkg.sv
// ----------------------------------------------------------------------------
// paa_pkg: shared types and constants for the posture average alarm
// Averaging depth, derived widths, reciprocal constant for the divide by the
// depth, timer limits and beep thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package paa_pkg;

    localparam int AVG_DEPTH = 10;
    localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    localparam int POS_W     = 16;
    localparam int POSZ_W    = 15;
    localparam int EL_W      = 16;
    localparam int SUM_W     = POS_W + 1 + $clog2(AVG_DEPTH);
    localparam int AVG_W     = 16;
    localparam int DIFF_W    = 17;
    localparam int SQ_W      = 33;
    localparam int DIST_W    = SQ_W + 2;
    localparam int R2_W      = 2 * POSZ_W;

    localparam int TIMER_W   = 24;
    localparam int ALERT_W   = 22;
    localparam int CD_W      = 25;
    localparam int PERIOD_W  = 14;

    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ALERT_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd4;

    // Reciprocal of the depth: exact floor division for every magnitude below 2^SUM_W.
    localparam int               DIV_K    = SUM_W + $clog2(AVG_DEPTH);
    localparam int               DIV_M_W  = SUM_W + 1;
    localparam longint unsigned  DIV_M_L  =
        ((64'd1 << DIV_K) + longint'(AVG_DEPTH) - 64'd1) / longint'(AVG_DEPTH);
    localparam logic [DIV_M_W-1:0] DIV_M  = DIV_M_L[DIV_M_W-1:0];
    localparam int               PROD_W   = SUM_W + DIV_M_W;

    localparam logic signed [CD_W-1:0] NEAR_POS_MS = CD_W'(50);
    localparam logic signed [CD_W-1:0] NEAR_NEG_MS = -CD_W'(50);
    localparam logic signed [CD_W-1:0] LONG_BAD_MS = -CD_W'(60000);
    localparam logic signed [CD_W-1:0] MID_BAD_MS  = -CD_W'(30000);

    localparam logic [PERIOD_W-1:0] PERIOD_FAST_MS = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0] PERIOD_MID_MS  = PERIOD_W'(5000);
    localparam logic [PERIOD_W-1:0] PERIOD_SLOW_MS = PERIOD_W'(10000);

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic        [POSZ_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_sums;

    function automatic logic signed [AVG_W-1:0] div_depth(input logic signed [SUM_W-1:0] n);
        logic [SUM_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [AVG_W-1:0]  q;
        mag  = n[SUM_W-1] ? (~n + SUM_W'(1)) : n;
        prod = PROD_W'(mag) * PROD_W'(DIV_M);
        q    = prod[DIV_K +: AVG_W];
        return n[SUM_W-1] ? $signed(~q + AVG_W'(1)) : $signed(q);
    endfunction

endpackage

FILE: design/paa_ring.sv
// ----------------------------------------------------------------------------
// paa_ring: ring of the last positions with running sums
// Overwrites the oldest slot on each load and updates the three sums in the
// same cycle. Reset clears ring, slot pointer and sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module paa_ring (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  paa_pkg::t_pos  i_pos,
    output paa_pkg::t_sums o_sums
);
    import paa_pkg::*;

    logic signed [POS_W-1:0]  r_ring_x [AVG_DEPTH];
    logic signed [POS_W-1:0]  r_ring_y [AVG_DEPTH];
    logic        [POSZ_W-1:0] r_ring_z [AVG_DEPTH];
    logic        [SLOT_W-1:0] r_slot;
    t_sums                    r_sums;
    t_sums                    n_sums;
    logic        [SLOT_W-1:0] n_slot;

    always_comb begin
        n_sums.x = r_sums.x + SUM_W'(i_pos.x) - SUM_W'(r_ring_x[r_slot]);
        n_sums.y = r_sums.y + SUM_W'(i_pos.y) - SUM_W'(r_ring_y[r_slot]);
        n_sums.z = r_sums.z + $signed(SUM_W'(i_pos.z)) - $signed(SUM_W'(r_ring_z[r_slot]));
        n_slot   = (r_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                r_ring_x[i] <= '0;
                r_ring_y[i] <= '0;
                r_ring_z[i] <= '0;
            end
            r_slot <= '0;
            r_sums <= '0;
        end else if (i_load) begin
            r_ring_x[r_slot] <= i_pos.x;
            r_ring_y[r_slot] <= i_pos.y;
            r_ring_z[r_slot] <= i_pos.z;
            r_slot           <= n_slot;
            r_sums           <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

FILE: design/posture_average_alarm.sv
// ----------------------------------------------------------------------------
// posture_average_alarm: averaged head position check with posture alarm
// Usage:
//   Input channel (i_in_valid / o_in_stall): one item per video frame with an
//   optional head position and the milliseconds since the previous frame.
//   Output channel (o_out_valid / i_out_stall): exactly one result item per
//   input item: posture_ok, beep and the countdown to the alert.
//   An item is taken at a rising edge with valid high and stall low.
//   Throughput: one item per cycle while the receiver does not stall. Each of
//   the five pipeline stages (ring and sums, divide by depth, squares, distance
//   compare, timers and beep) is one registered pass, and the ring and timers
//   each close their loop through one register. Results leave the stage 5 registers.
//   When the receiver stalls, the result holds and the pipeline fills; the
//   input stalls only when all five stages hold items.
//   Config: i_cfg_we writes register i_cfg_idx (0 alert time, 1..3 neutral x/y/z,
//   4 radius). The user must write only while the block is idle; not enforced.
//   Reset (i_rst_n low, synchronous): ring, sums, timers and pipeline cleared,
//   registers back to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module posture_average_alarm (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [paa_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [paa_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_has_position,
    input  logic signed [paa_pkg::POS_W-1:0]      i_pos_x_mm,
    input  logic signed [paa_pkg::POS_W-1:0]      i_pos_y_mm,
    input  logic        [paa_pkg::POSZ_W-1:0]     i_pos_z_mm,
    input  logic        [paa_pkg::EL_W-1:0]       i_elapsed_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_posture_ok,
    output logic                                  o_beep,
    output logic signed [paa_pkg::CD_W-1:0]       o_countdown_ms
);
    import paa_pkg::*;

    logic [ALERT_W-1:0]       r_alert_time;
    logic signed [POS_W-1:0]  r_neutral_x;
    logic signed [POS_W-1:0]  r_neutral_y;
    logic [POSZ_W-1:0]        r_neutral_z;
    logic [POSZ_W-1:0]        r_radius;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic ready1, ready2, ready3, ready4, ready5;
    logic accept;

    t_pos  pos;
    t_sums sums;

    logic [EL_W-1:0]          r_el1, r_el2, r_el3, r_el4;
    logic signed [AVG_W-1:0]  r_avg_x, r_avg_y, r_avg_z;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic signed [2*DIFF_W-1:0] sq_x, sq_y, sq_z;
    logic [SQ_W-1:0]          r_sq_x, r_sq_y, r_sq_z;
    logic [R2_W-1:0]          r_r2;
    logic [DIST_W-1:0]        dist2;
    logic                     r_good4;

    logic [TIMER_W-1:0]       r_ms_since_good, r_ms_since_beep;
    logic [TIMER_W-1:0]       n_ms_since_good, n_ms_since_beep;
    logic [TIMER_W:0]         good_add, beep_add;
    logic [TIMER_W-1:0]       beep_sat;
    logic signed [CD_W-1:0]   n_countdown;
    logic [PERIOD_W-1:0]      period;
    logic                     n_beep;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert_time <= ALERT_W'(30000);
            r_neutral_x  <= '0;
            r_neutral_y  <= '0;
            r_neutral_z  <= POSZ_W'(600);
            r_radius     <= POSZ_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALERT_TIME: r_alert_time <= i_cfg_wdata[ALERT_W-1:0];
                REG_NEUTRAL_X:  r_neutral_x  <= $signed(i_cfg_wdata[POS_W-1:0]);
                REG_NEUTRAL_Y:  r_neutral_y  <= $signed(i_cfg_wdata[POS_W-1:0]);
                REG_NEUTRAL_Z:  r_neutral_z  <= i_cfg_wdata[POSZ_W-1:0];
                REG_RADIUS:     r_radius     <= i_cfg_wdata[POSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign ready5     = !r_v5 || !i_out_stall;
    assign ready4     = !r_v4 || ready5;
    assign ready3     = !r_v3 || ready4;
    assign ready2     = !r_v2 || ready3;
    assign ready1     = !r_v1 || ready2;
    assign o_in_stall = !ready1;
    assign accept     = i_in_valid && ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= i_in_valid;
            if (ready2) r_v2 <= r_v1;
            if (ready3) r_v3 <= r_v2;
            if (ready4) r_v4 <= r_v3;
            if (ready5) r_v5 <= r_v4;
        end
    end

    // Stage 1: ring and running sums
    assign pos.x = i_pos_x_mm;
    assign pos.y = i_pos_y_mm;
    assign pos.z = i_pos_z_mm;

    paa_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && i_has_position),
        .i_pos   (pos),
        .o_sums  (sums)
    );

    always_ff @(posedge i_clk) begin
        if (accept) r_el1 <= i_elapsed_ms;
    end

    // Stage 2: divide sums by depth
    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_avg_x <= div_depth(sums.x);
            r_avg_y <= div_depth(sums.y);
            r_avg_z <= div_depth(sums.z);
            r_el2   <= r_el1;
        end
    end

    // Stage 3: squared offsets from neutral
    always_comb begin
        dx   = DIFF_W'(r_avg_x) - DIFF_W'(r_neutral_x);
        dy   = DIFF_W'(r_avg_y) - DIFF_W'(r_neutral_y);
        dz   = DIFF_W'(r_avg_z) - $signed(DIFF_W'(r_neutral_z));
        sq_x = dx * dx;
        sq_y = dy * dy;
        sq_z = dz * dz;
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && r_v2) begin
            r_sq_x <= sq_x[SQ_W-1:0];
            r_sq_y <= sq_y[SQ_W-1:0];
            r_sq_z <= sq_z[SQ_W-1:0];
            r_r2   <= R2_W'(r_radius) * R2_W'(r_radius);
            r_el3  <= r_el2;
        end
    end

    // Stage 4: distance compare
    assign dist2 = DIST_W'(r_sq_x) + DIST_W'(r_sq_y) + DIST_W'(r_sq_z);

    always_ff @(posedge i_clk) begin
        if (ready4 && r_v3) begin
            r_good4 <= (dist2 <= DIST_W'(r_r2));
            r_el4   <= r_el3;
        end
    end

    // Stage 5: timers, countdown and beep
    always_comb begin
        good_add = (TIMER_W + 1)'(r_ms_since_good) + (TIMER_W + 1)'(r_el4);
        beep_add = (TIMER_W + 1)'(r_ms_since_beep) + (TIMER_W + 1)'(r_el4);
        beep_sat = beep_add[TIMER_W] ? '1 : beep_add[TIMER_W-1:0];
        if (r_good4) begin
            n_ms_since_good = '0;
        end else begin
            n_ms_since_good = good_add[TIMER_W] ? '1 : good_add[TIMER_W-1:0];
        end
        n_countdown = $signed(CD_W'(r_alert_time)) - $signed(CD_W'(n_ms_since_good));

        if (n_countdown < LONG_BAD_MS) begin
            period = PERIOD_FAST_MS;
        end else if (n_countdown < MID_BAD_MS) begin
            period = PERIOD_MID_MS;
        end else begin
            period = PERIOD_SLOW_MS;
        end

        if (n_countdown < NEAR_POS_MS && n_countdown > NEAR_NEG_MS) begin
            n_beep = 1'b1;
        end else if (n_countdown[CD_W-1]) begin
            n_beep = (beep_sat > TIMER_W'(period));
        end else begin
            n_beep = 1'b0;
        end
        n_ms_since_beep = n_beep ? '0 : beep_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_since_good <= '0;
            r_ms_since_beep <= '0;
        end else if (ready5 && r_v4) begin
            r_ms_since_good <= n_ms_since_good;
            r_ms_since_beep <= n_ms_since_beep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready5 && r_v4) begin
            o_posture_ok   <= r_good4;
            o_beep         <= n_beep;
            o_countdown_ms <= n_countdown;
        end
    end

    assign o_out_valid = r_v5;

    // Checks
    a_beep_near_or_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_beep |-> (o_countdown_ms < NEAR_POS_MS))
        else $error("beep with countdown well above zero");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_out_stall))
        else $error("input stalled while pipeline has room");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_good_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_posture_ok && $changed(o_countdown_ms)
            |-> (r_ms_since_good == '0) || $past(r_v4 && ready5) == 1'b0)
        else $error("good posture left the since-good timer running");

endmodule
